### hdl/assert_macros.svh
// Assertion helpers; clk and rst_n must be in scope where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

### hdl/fab_pkg.sv
package fab_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int ADDR_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int LEN_W      = ADDR_BITS + 1;
  localparam int ALOG_W     = 4;
  localparam int FUNC_W     = 2;
  localparam int SPLIT_MIN  = 3;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     len;
    logic                 free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef logic [2:0] wr_sel_t;
  localparam wr_sel_t WR_SHIFT    = 3'd0;
  localparam wr_sel_t WR_INIT     = 3'd1;
  localparam wr_sel_t WR_SPLIT_HI = 3'd2;
  localparam wr_sel_t WR_TAKE     = 3'd3;
  localparam wr_sel_t WR_MERGE    = 3'd4;

  typedef struct packed {
    logic             ld_op;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    wr_sel_t          wr_sel;
    logic [IDX_W-1:0] wr_addr;
    logic             split;
    logic             cap_cur;
    logic             cap_nxt;
    logic             cap_prv;
    logic             use_nxt;
    logic             use_prv;
    logic             off_ld;
    logic             ld_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic can_split;
    logic nxt_free;
    logic prv_free;
  } sts_t;

endpackage

### hdl/fab_ram.sv
module fab_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/fab_datapath.sv
module fab_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [fab_pkg::ADDR_BITS-1:0]  cfg_wr_data,
  input  logic [fab_pkg::FUNC_W-1:0]     in_func,
  input  logic [fab_pkg::ADDR_BITS-1:0]  in_req_size,
  input  logic [fab_pkg::ALOG_W-1:0]     in_align_log2,
  input  logic [fab_pkg::ADDR_BITS-1:0]  in_free_offset,
  input  fab_pkg::cmd_t                  cmd,
  output fab_pkg::sts_t                  sts,
  output logic [fab_pkg::ADDR_BITS-1:0]  out_offset
);

  localparam int AB = fab_pkg::ADDR_BITS;
  localparam int LW = fab_pkg::LEN_W;

  logic [AB-1:0]                pool_r;
  logic [fab_pkg::FUNC_W-1:0]   op_func_r;
  logic [AB-1:0]                size_r;
  logic [fab_pkg::ALOG_W-1:0]   alog_r;
  logic [AB-1:0]                foff_r;
  logic [AB-1:0]                cur_start_r;
  logic [LW-1:0]                cur_len_r;
  logic [LW-1:0]                aligned_r;
  logic [LW-1:0]                need_r;
  logic [LW-1:0]                nxt_len_r;
  logic                         nxt_free_r;
  logic [AB-1:0]                prv_start_r;
  logic [LW-1:0]                prv_len_r;
  logic                         prv_free_r;
  logic [AB-1:0]                res_off_r;
  logic [AB-1:0]                out_offset_r;

  logic [fab_pkg::ENTRY_W-1:0]  rd_data;
  logic [fab_pkg::ENTRY_W-1:0]  wr_data;
  fab_pkg::entry_t              rd_e;
  fab_pkg::entry_t              wr_e;

  logic [AB-1:0]   align_m1;
  logic [LW-1:0]   aligned;
  logic [LW-1:0]   pad;
  logic [LW:0]     need;
  logic [LW:0]     blk_end;
  logic            fit;
  logic            fhit;

  fab_ram #(.W(fab_pkg::ENTRY_W), .D(fab_pkg::MAX_BLOCKS)) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (wr_data),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  assign rd_e = fab_pkg::entry_t'(rd_data);

  // alignment padding, fit, split and free-lookup tests on the entry just read
  always_comb begin
    align_m1 = ~({AB{1'b1}} << alog_r);
    aligned  = ({1'b0, rd_e.start} + {1'b0, align_m1}) & ~{1'b0, align_m1};
    pad      = aligned - {1'b0, rd_e.start};
    need     = {2'b00, size_r} + {1'b0, pad};
    fit      = rd_e.free && ({1'b0, rd_e.len} >= need);
    blk_end  = {2'b00, rd_e.start} + {1'b0, rd_e.len};
    fhit     = ((rd_e.start <= foff_r) && ({2'b00, foff_r} < blk_end)) ||
               ((rd_e.len == '0) && (rd_e.start == foff_r));
    sts.hit       = (op_func_r == fab_pkg::FUNC_ALLOC) ? fit : fhit;
    sts.can_split = {1'b0, rd_e.len} > (need + (LW+1)'(fab_pkg::SPLIT_MIN));
    sts.nxt_free  = nxt_free_r;
    sts.prv_free  = prv_free_r;
  end

  always_comb begin
    wr_e = rd_e;
    unique case (cmd.wr_sel)
      fab_pkg::WR_SHIFT: begin
        wr_e = rd_e;
      end
      fab_pkg::WR_INIT: begin
        wr_e.start = '0;
        wr_e.len   = {1'b0, pool_r};
        wr_e.free  = 1'b1;
      end
      fab_pkg::WR_SPLIT_HI: begin
        wr_e.start = aligned_r[AB-1:0] + size_r;
        wr_e.len   = cur_len_r - need_r;
        wr_e.free  = 1'b1;
      end
      fab_pkg::WR_TAKE: begin
        wr_e.start = cur_start_r;
        wr_e.len   = cmd.split ? need_r : cur_len_r;
        wr_e.free  = 1'b0;
      end
      fab_pkg::WR_MERGE: begin
        wr_e.start = cmd.use_prv ? prv_start_r : cur_start_r;
        wr_e.len   = cur_len_r + (cmd.use_nxt ? nxt_len_r : '0)
                     + (cmd.use_prv ? prv_len_r : '0);
        wr_e.free  = 1'b1;
      end
      default: begin
        wr_e = rd_e;
      end
    endcase
  end

  assign wr_data = wr_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= '0;
    end else if (cfg_wr_en) begin
      pool_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_op) begin
      op_func_r <= in_func;
      size_r    <= in_req_size;
      alog_r    <= in_align_log2;
      foff_r    <= in_free_offset;
      res_off_r <= '0;
    end
    if (cmd.cap_cur) begin
      cur_start_r <= rd_e.start;
      cur_len_r   <= rd_e.len;
      aligned_r   <= aligned;
      need_r      <= need[LW-1:0];
    end
    if (cmd.off_ld) begin
      res_off_r <= aligned[AB-1:0];
    end
    if (cmd.cap_nxt) begin
      nxt_len_r  <= rd_e.len;
      nxt_free_r <= rd_e.free;
    end
    if (cmd.cap_prv) begin
      prv_start_r <= rd_e.start;
      prv_len_r   <= rd_e.len;
      prv_free_r  <= rd_e.free;
    end
    if (cmd.ld_out) begin
      out_offset_r <= res_off_r;
    end
  end

  assign out_offset = out_offset_r;

endmodule

### hdl/fab_ctrl.sv
`include "assert_macros.svh"

module fab_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fab_pkg::FUNC_W-1:0]  in_func,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  input  fab_pkg::sts_t               sts,
  output fab_pkg::cmd_t               cmd
);

  localparam int IW = fab_pkg::IDX_W;
  localparam int CW = fab_pkg::CNT_W;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_NXT   = 4'd3;
  localparam logic [3:0] S_PRV   = 4'd4;
  localparam logic [3:0] S_MRG   = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_FIX_A = 4'd7;
  localparam logic [3:0] S_FIX_B = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [IW-1:0] didx_r, didx_nxt;
  logic          dvld_r, dvld_nxt;
  logic [IW-1:0] hidx_r, hidx_nxt;
  logic          alloc_r, alloc_nxt;
  logic          split_r, split_nxt;
  logic [CW-1:0] src_r, src_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          up_r, up_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pdst_r, pdst_nxt;
  logic          use_nxt_r, use_nxt_nxt;
  logic          use_prv_r, use_prv_nxt;
  logic [IW-1:0] mpos_r, mpos_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;

  logic          has_nxt;
  logic          has_prv;
  logic          nf;
  logic          pf;
  logic [1:0]    k;
  logic [CW-1:0] p;

  assign has_nxt = (CW'(hidx_r) + CW'(1)) < cnt_r;
  assign has_prv = hidx_r != '0;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    didx_nxt    = didx_r;
    dvld_nxt    = 1'b0;
    hidx_nxt    = hidx_r;
    alloc_nxt   = alloc_r;
    split_nxt   = split_r;
    src_nxt     = src_r;
    rem_nxt     = rem_r;
    up_nxt      = up_r;
    k_nxt       = k_r;
    pend_nxt    = 1'b0;
    pdst_nxt    = pdst_r;
    use_nxt_nxt = use_nxt_r;
    use_prv_nxt = use_prv_r;
    mpos_nxt    = mpos_r;
    res_ok_nxt  = res_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt  = out_ok_r;
    in_ready    = 1'b0;
    nf          = has_nxt && sts.nxt_free;
    pf          = has_prv && sts.prv_free;
    k           = {1'b0, nf} + {1'b0, pf};
    p           = pf ? CW'(hidx_r) : (CW'(hidx_r) + CW'(1));

    cmd         = '0;
    cmd.wr_sel  = fab_pkg::WR_SHIFT;
    cmd.split   = split_r;
    cmd.use_nxt = use_nxt_r;
    cmd.use_prv = use_prv_r;

    unique case (state_r)
      S_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = fab_pkg::WR_INIT;
        cmd.wr_addr = '0;
        cnt_nxt     = CW'(1);
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_op = 1'b1;
          ptr_nxt   = '0;
          alloc_nxt = in_func == fab_pkg::FUNC_ALLOC;
          if (in_func == fab_pkg::FUNC_ALLOC || in_func == fab_pkg::FUNC_FREE) begin
            state_nxt = S_SCAN;
          end else if (in_func == fab_pkg::FUNC_CLEAR) begin
            state_nxt = S_CLR;
          end else begin
            res_ok_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        // one read a cycle; data for didx_r arrives while ptr_r is issued
        if (ptr_r < cnt_r) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = ptr_r[IW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
          dvld_nxt    = 1'b1;
          didx_nxt    = ptr_r[IW-1:0];
        end
        if (dvld_r) begin
          if (sts.hit) begin
            dvld_nxt    = 1'b0;
            cmd.cap_cur = 1'b1;
            hidx_nxt    = didx_r;
            res_ok_nxt  = 1'b1;
            if (alloc_r) begin
              cmd.off_ld = 1'b1;
              split_nxt  = sts.can_split && (cnt_r < CW'(fab_pkg::MAX_BLOCKS));
              up_nxt     = 1'b1;
              src_nxt    = cnt_r - CW'(1);
              rem_nxt    = cnt_r - CW'(1) - CW'(didx_r);
              if (!(sts.can_split && (cnt_r < CW'(fab_pkg::MAX_BLOCKS)))) begin
                state_nxt = S_FIX_B;
              end else if (cnt_r - CW'(1) - CW'(didx_r) != '0) begin
                state_nxt = S_SHIFT;
              end else begin
                state_nxt = S_FIX_A;
              end
            end else begin
              // read of the next entry is already in flight
              state_nxt = S_NXT;
            end
          end else if (CW'(didx_r) + CW'(1) == cnt_r) begin
            dvld_nxt   = 1'b0;
            res_ok_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        end
      end
      S_NXT: begin
        cmd.cap_nxt = 1'b1;
        if (has_prv) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = hidx_r - IW'(1);
        end
        state_nxt = S_PRV;
      end
      S_PRV: begin
        cmd.cap_prv = 1'b1;
        state_nxt   = S_MRG;
      end
      S_MRG: begin
        use_nxt_nxt = nf;
        use_prv_nxt = pf;
        k_nxt       = k;
        up_nxt      = 1'b0;
        src_nxt     = p + CW'(k);
        rem_nxt     = (k == '0) ? '0 : (cnt_r - p - CW'(k));
        mpos_nxt    = pf ? (hidx_r - IW'(1)) : hidx_r;
        if (k != '0 && (cnt_r - p - CW'(k)) != '0) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_FIX_B;
        end
      end
      S_SHIFT: begin
        if (rem_r != '0) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = src_r[IW-1:0];
          pend_nxt    = 1'b1;
          rem_nxt     = rem_r - CW'(1);
          pdst_nxt    = up_r ? (src_r[IW-1:0] + IW'(1)) : (src_r[IW-1:0] - IW'(k_r));
          src_nxt     = up_r ? (src_r - CW'(1)) : (src_r + CW'(1));
        end
        if (pend_r) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = fab_pkg::WR_SHIFT;
          cmd.wr_addr = pdst_r;
          if (rem_r == '0) begin
            state_nxt = alloc_r ? S_FIX_A : S_FIX_B;
          end
        end
      end
      S_FIX_A: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = fab_pkg::WR_SPLIT_HI;
        cmd.wr_addr = hidx_r + IW'(1);
        state_nxt   = S_FIX_B;
      end
      S_FIX_B: begin
        cmd.wr_en = 1'b1;
        if (alloc_r) begin
          cmd.wr_sel  = fab_pkg::WR_TAKE;
          cmd.wr_addr = hidx_r;
          if (split_r) begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end else begin
          cmd.wr_sel  = fab_pkg::WR_MERGE;
          cmd.wr_addr = mpos_r;
          cnt_nxt     = cnt_r - CW'(k_r);
        end
        state_nxt = S_DONE;
      end
      S_CLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = fab_pkg::WR_INIT;
        cmd.wr_addr = '0;
        cnt_nxt     = CW'(1);
        res_ok_nxt  = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= CW'(1);
      dvld_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dvld_r      <= dvld_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    didx_r    <= didx_nxt;
    hidx_r    <= hidx_nxt;
    alloc_r   <= alloc_nxt;
    split_r   <= split_nxt;
    src_r     <= src_nxt;
    rem_r     <= rem_nxt;
    up_r      <= up_nxt;
    k_r       <= k_nxt;
    pdst_r    <= pdst_nxt;
    use_nxt_r <= use_nxt_nxt;
    use_prv_r <= use_prv_nxt;
    mpos_r    <= mpos_nxt;
    res_ok_r  <= res_ok_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

  `ASSERT_IMPL(a_cnt_range, 1'b1, (cnt_r != '0) && (cnt_r <= CW'(fab_pkg::MAX_BLOCKS)))
  `ASSERT_IMPL(a_rw_apart, cmd.wr_en && cmd.rd_en, cmd.wr_addr != cmd.rd_addr)
  `ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r != S_IDLE)

endmodule

### hdl/first_fit_block_allocator_core.sv
// First-fit block allocator with coalescing over a pool of pool_size units.
// Input channel (in_valid/in_ready): one beat per request; in_func selects
//   allocate (in_req_size, in_align_log2), free (in_free_offset) or clear.
// Result channel (out_valid/out_ready): exactly one beat per request with
//   out_ok and out_offset (aligned offset of an allocation, else zero).
// Config: cfg_wr_en/cfg_wr_data write pool_size; used at the next clear.
// Steps: the scan reads the table in order up to the first hit (a miss
//   answers once all blocks are read); an allocate taken whole then writes
//   its entry, a split moves later entries up, writes the free remainder,
//   then the taken entry; a free fetches both neighbours, moves later entries
//   down if it merges, then writes the merged one. Clear rewrites entry 0.
//   The table RAM has one read and one write port with registered read, so
//   the scan and the entry shuffle each advance one entry a cycle.
// One request is in flight at a time; the next beat is taken the cycle after
//   the previous result reaches the output register, even if that still waits.
// Reset (rst_n low, synchronous): pool_size 0, table rebuilt as one free
//   block of length zero in the init state after reset, no result pending.
// Receiver stall: the result holds in the output register; a finished
//   request behind it waits in its done state until the register frees.
module first_fit_block_allocator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fab_pkg::FUNC_W-1:0]     in_func,
  input  logic [fab_pkg::ADDR_BITS-1:0]  in_req_size,
  input  logic [fab_pkg::ALOG_W-1:0]     in_align_log2,
  input  logic [fab_pkg::ADDR_BITS-1:0]  in_free_offset,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [fab_pkg::ADDR_BITS-1:0]  out_offset,
  input  logic                           cfg_wr_en,
  input  logic [fab_pkg::ADDR_BITS-1:0]  cfg_wr_data
);

  fab_pkg::cmd_t cmd;   // controller to datapath
  fab_pkg::sts_t sts;   // datapath to controller

  // Sequencer: scan, neighbour fetch, entry shuffle, final writes.
  fab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ok    (out_ok),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table RAM, fit and lookup arithmetic, merge sums, offset register.
  fab_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_func        (in_func),
    .in_req_size    (in_req_size),
    .in_align_log2  (in_align_log2),
    .in_free_offset (in_free_offset),
    .cmd            (cmd),
    .sts            (sts),
    .out_offset     (out_offset)
  );

endmodule

### sim/fab_checker.sv
module fab_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [fab_pkg::FUNC_W-1:0]    in_func,
  input  logic [fab_pkg::ADDR_BITS-1:0] in_req_size,
  input  logic [fab_pkg::ALOG_W-1:0]    in_align_log2,
  input  logic [fab_pkg::ADDR_BITS-1:0] in_free_offset,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_ok,
  input  logic [fab_pkg::ADDR_BITS-1:0] out_offset,
  input  logic                          cfg_wr_en,
  input  logic [fab_pkg::ADDR_BITS-1:0] cfg_wr_data,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = fab_pkg::ADDR_BITS;
  localparam int LW = fab_pkg::LEN_W;
  localparam int MB = fab_pkg::MAX_BLOCKS;

  typedef struct {
    bit          ok;
    bit [AW-1:0] offset;
  } reply_t;

  reply_t        replies_due[$];
  bit [AW-1:0]   pool_units;
  bit [AW-1:0]   blk_start [MB];
  bit [LW-1:0]   blk_len   [MB];
  bit            blk_free  [MB];
  int            blk_count;

  task automatic rebuild_table();
    for (int i = 0; i < MB; i++) begin
      blk_start[i] = '0;
      blk_len[i]   = '0;
      blk_free[i]  = 1'b0;
    end
    blk_len[0]  = {1'b0, pool_units};
    blk_free[0] = 1'b1;
    blk_count   = 1;
  endtask

  task automatic drop_entry(int k);
    for (int j = k; j + 1 < blk_count; j++) begin
      blk_start[j] = blk_start[j+1];
      blk_len[j]   = blk_len[j+1];
      blk_free[j]  = blk_free[j+1];
    end
    blk_count--;
  endtask

  task automatic place_block(bit [AW-1:0] size, bit [fab_pkg::ALOG_W-1:0] alog,
                             output reply_t r);
    longint unsigned align, s, aligned, need;
    align = 64'd1 << alog;
    r.ok = 1'b0;
    r.offset = '0;
    for (int i = 0; i < blk_count; i++) begin
      s = 64'(blk_start[i]);
      aligned = (s + align - 1) & ~(align - 1);
      need = 64'(size) + (aligned - s);
      if (!blk_free[i] || 64'(blk_len[i]) < need) continue;
      if (64'(blk_len[i]) > need + fab_pkg::SPLIT_MIN && blk_count < MB) begin
        for (int j = blk_count; j > i + 1; j--) begin
          blk_start[j] = blk_start[j-1];
          blk_len[j]   = blk_len[j-1];
          blk_free[j]  = blk_free[j-1];
        end
        blk_start[i+1] = AW'(aligned + 64'(size));
        blk_len[i+1]   = LW'(64'(blk_len[i]) - need);
        blk_free[i+1]  = 1'b1;
        blk_count++;
        blk_len[i] = LW'(need);
      end
      blk_free[i] = 1'b0;
      r.ok = 1'b1;
      r.offset = aligned[AW-1:0];
      return;
    end
  endtask

  task automatic release_block(bit [AW-1:0] off, output reply_t r);
    longint unsigned s, len;
    r.ok = 1'b0;
    r.offset = '0;
    for (int i = 0; i < blk_count; i++) begin
      s = 64'(blk_start[i]);
      len = 64'(blk_len[i]);
      if (!((s <= 64'(off) && 64'(off) < s + len) || (len == 0 && s == 64'(off)))) continue;
      blk_free[i] = 1'b1;
      if (i + 1 < blk_count && blk_free[i+1]) begin
        blk_len[i] += blk_len[i+1];
        drop_entry(i + 1);
      end
      if (i > 0 && blk_free[i-1]) begin
        blk_len[i-1] += blk_len[i];
        drop_entry(i);
      end
      r.ok = 1'b1;
      return;
    end
  endtask

  always @(posedge clk) begin
    reply_t r, got, want;
    if (!rst_n) begin
      pool_units = '0;
      rebuild_table();
      replies_due.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.ok = out_ok;
        got.offset = out_offset;
        if (replies_due.size() == 0) begin
          $error("result beat with nothing expected: ok=%0d offset=%0d", got.ok, got.offset);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_ok);
            errors++;
          end
          if (out_offset !== want.offset) begin
            $error("offset: expected %0d, got %0d", want.offset, out_offset);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        r.ok = 1'b0;
        r.offset = '0;
        case (in_func)
          fab_pkg::FUNC_ALLOC: place_block(in_req_size, in_align_log2, r);
          fab_pkg::FUNC_FREE:  release_block(in_free_offset, r);
          fab_pkg::FUNC_CLEAR: begin
            rebuild_table();
            r.ok = 1'b1;
          end
          default: ;
        endcase
        replies_due.insert(replies_due.size(), r);
      end
      if (cfg_wr_en) pool_units = cfg_wr_data;
    end
    pending = replies_due.size();
  end
endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // func code with no operation behind it
  localparam logic [fab_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 2 * fab_pkg::MAX_BLOCKS + 40;  // worst-case latency plus slack

  logic                          clk, rst_n;
  logic                          in_valid, in_ready;
  logic [fab_pkg::FUNC_W-1:0]    in_func;
  logic [fab_pkg::ADDR_BITS-1:0] in_req_size, in_free_offset;
  logic [fab_pkg::ALOG_W-1:0]    in_align_log2;
  logic                          out_valid, out_ready, out_ok;
  logic [fab_pkg::ADDR_BITS-1:0] out_offset;
  logic                          cfg_wr_en;
  logic [fab_pkg::ADDR_BITS-1:0] cfg_wr_data;
  int                            errors, pending;

  first_fit_block_allocator_core dut (.*);

  fab_checker chk (.*);

  // bookkeeping on the stimulus side: what was sent, which offsets are live
  logic [fab_pkg::FUNC_W-1:0]    sent_funcs[$];
  logic [fab_pkg::ADDR_BITS-1:0] live_offsets[$];
  int  beats_in, beats_out, n_alloc, n_free, n_clear, n_placed;
  int  cycles;
  bit  hold_req, hold_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // track beats and harvest offsets handed out by successful allocations
  always @(posedge clk) begin
    logic [fab_pkg::FUNC_W-1:0] f;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sent_funcs.insert(sent_funcs.size(), in_func);
        beats_in++;
        case (in_func)
          fab_pkg::FUNC_ALLOC: n_alloc++;
          fab_pkg::FUNC_FREE:  n_free++;
          fab_pkg::FUNC_CLEAR: n_clear++;
          default: ;
        endcase
      end
      if (out_valid && out_ready && sent_funcs.size() > 0) begin
        f = sent_funcs.pop_front();
        beats_out++;
        if (f == fab_pkg::FUNC_ALLOC && out_ok) begin
          n_placed++;
          live_offsets.insert(live_offsets.size(), out_offset);
          if (live_offsets.size() > 80) void'(live_offsets.pop_front());
        end
        if (f == fab_pkg::FUNC_CLEAR) live_offsets.delete();
      end
    end
  end

  // receiver: random stalls in spells, clean stretches, one long hold-off
  initial begin
    int mode, run;
    out_ready = 1'b0;
    hold_seen = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (600) @(negedge clk);
      end
      mode = int'($urandom_range(0, 3));
      run  = int'($urandom_range(4, 40));
      repeat (run) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0) || (run < 8);
        endcase
      end
    end
  end

  // one beat: present at the falling edge, hold until taken at a rising edge
  task automatic send(logic [fab_pkg::FUNC_W-1:0] f, logic [fab_pkg::ADDR_BITS-1:0] size,
                      logic [fab_pkg::ALOG_W-1:0] alog, logic [fab_pkg::ADDR_BITS-1:0] off);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_func        <= f;
    in_req_size    <= size;
    in_align_log2  <= alog;
    in_free_offset <= off;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // block idle: everything answered, then let the table work settle
  task automatic set_pool(logic [fab_pkg::ADDR_BITS-1:0] units);
    pause(0);
    wait (beats_in == beats_out);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= units;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 16'($urandom());
  endtask

  task automatic random_item(int units);
    int pick, k;
    logic [fab_pkg::ADDR_BITS-1:0] size, off;
    logic [fab_pkg::ALOG_W-1:0]    alog;
    pick = int'($urandom_range(0, 99));
    alog = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 4));
    size = ($urandom_range(0, 19) == 0) ? 16'($urandom())
                                        : 16'($urandom_range(0, units / 10 + 4));
    off  = 16'($urandom());
    if (pick < 52) begin
      send(fab_pkg::FUNC_ALLOC, size, alog, off);
    end else if (pick < 90) begin
      if (live_offsets.size() > 0 && pick < 85) begin
        k = int'($urandom_range(0, live_offsets.size() - 1));
        off = live_offsets[k];
        live_offsets.delete(k);
        // sometimes point inside the block rather than at its start
        if ($urandom_range(0, 4) == 0) off = off + 16'($urandom_range(0, 3));
      end
      send(fab_pkg::FUNC_FREE, size, alog, off);
    end else if (pick < 95) begin
      send(fab_pkg::FUNC_CLEAR, size, alog, off);
    end else begin
      send(FUNC_NONE, size, alog, off);
    end
  endtask

  initial begin
    int pools[6];
    int burst;
    pools = '{1000, 65535, 64, 5000, 257, 0};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = fab_pkg::FUNC_ALLOC;
    in_req_size = '0;
    in_align_log2 = '0;
    in_free_offset = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_req = 1'b0;
    cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pool straight out of reset: the zero-length block still takes a
    // zero-size request and can be found again by its start
    send(fab_pkg::FUNC_ALLOC, 16'd0, 4'd0, 16'd0);
    send(fab_pkg::FUNC_FREE, 16'd0, 4'd0, 16'd0);
    send(fab_pkg::FUNC_ALLOC, 16'd1, 4'd0, 16'd0);
    send(FUNC_NONE, 16'hFFFF, 4'hF, 16'hFFFF);
    send(fab_pkg::FUNC_FREE, 16'd0, 4'd0, 16'd7);

    // full-size pool: extremes of every field, alignment padding, merges
    set_pool(16'hFFFF);
    send(fab_pkg::FUNC_CLEAR, 16'd0, 4'd0, 16'd0);
    send(fab_pkg::FUNC_ALLOC, 16'hFFFF, 4'd0, 16'd0);
    send(fab_pkg::FUNC_ALLOC, 16'd1, 4'd0, 16'd0);           // out of memory
    send(fab_pkg::FUNC_FREE, 16'd0, 4'd0, 16'hFFFE);         // offset inside the block
    send(fab_pkg::FUNC_ALLOC, 16'd100, 4'hF, 16'd0);
    send(fab_pkg::FUNC_ALLOC, 16'd5, 4'hF, 16'd0);           // padded up to the half
    send(fab_pkg::FUNC_ALLOC, 16'd3, 4'd2, 16'd0);
    send(fab_pkg::FUNC_FREE, 16'd0, 4'd0, 16'd32768);
    send(fab_pkg::FUNC_FREE, 16'd0, 4'd0, 16'd0);            // merges with the block after it
    send(fab_pkg::FUNC_FREE, 16'd0, 4'd0, 16'd0);            // already free
    send(fab_pkg::FUNC_ALLOC, 16'hFFFF, 4'hF, 16'hFFFF);
    send(fab_pkg::FUNC_ALLOC, 16'd0, 4'd7, 16'd0);

    // table full: unit allocations split until no entry is left, then the
    // remainder is handed out whole
    set_pool(16'd300);
    send(fab_pkg::FUNC_CLEAR, 16'd0, 4'd0, 16'd0);
    repeat (fab_pkg::MAX_BLOCKS + 4)
      send(fab_pkg::FUNC_ALLOC, 16'd1, 4'd0, 16'($urandom()));
    send(fab_pkg::FUNC_FREE, 16'd0, 4'd0, 16'd5);
    send(fab_pkg::FUNC_FREE, 16'd0, 4'd0, 16'd6);

    // random phases across pool sizes; bursts with gaps in between
    foreach (pools[p]) begin
      set_pool(16'(pools[p]));
      send(fab_pkg::FUNC_CLEAR, 16'd0, 4'd0, 16'd0);
      if (p == 1) hold_req = 1'b1;  // receiver backs off while we keep sending
      for (int n = 0; n < 210; ) begin
        burst = ($urandom_range(0, 3) == 0) ? 60 : int'($urandom_range(1, 12));
        for (int b = 0; b < burst && n < 210; b++, n++) random_item(pools[p]);
        pause(int'($urandom_range(0, 8)));
      end
    end

    pause(0);
    wait (beats_in == beats_out && pending == 0);
    repeat (SETTLE) @(posedge clk);
    $display("%0d requests: %0d allocate (%0d placed), %0d free, %0d clear",
             beats_in, n_alloc, n_placed, n_free, n_clear);
    $display("pool sizes from 0 to 65535, table-full splits and a long result hold-off");
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
